// ----- hdl/tps_pkg.sv -----
`timescale 1ns / 1ps

package tps_pkg;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 18;
  localparam int DIFF_W  = COORD_W + 1;            // v - origin, o - l
  localparam int PROD_W  = NORM_W + DIFF_W;        // one normal product
  localparam int SIDE_W  = 52;                     // sum of three products
  localparam int SLM_W   = SIDE_W - 1;             // |side| magnitude
  localparam int DENM_W  = SIDE_W;                 // |side_o - side_l|
  localparam int SPLIT_W = 25;                     // low slice of |side| per partial product
  localparam int NUM_W   = SLM_W + DIFF_W;         // exact |side| * |d|
  localparam int QUO_W   = DIFF_W;                 // quotient never exceeds |d|
  localparam int LANE_LAT = 3 + QUO_W + 1;         // crossing lane depth
  localparam int SIDE_LAT = 2;                     // plane evaluation depth
  localparam int PIPE_LAT = SIDE_LAT + 1 + LANE_LAT;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd5;

  localparam logic signed [NORM_W-1:0] NORMAL_Z_RST = 18'sd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [SIDE_W-1:0]  side_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } nrm3_t;

  typedef struct packed {
    coord_t vert0_x;
    coord_t vert0_y;
    coord_t vert0_z;
    coord_t vert1_x;
    coord_t vert1_y;
    coord_t vert1_z;
    coord_t vert2_x;
    coord_t vert2_y;
    coord_t vert2_z;
  } tri_in_t;

  typedef struct packed {
    logic   cut;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } seg_out_t;

endpackage

// ----- hdl/tps_side_lane.sv -----
`timescale 1ns / 1ps

// Plane value of one vertex: n . (v - origin), two stages.
module tps_side_lane (
  input  logic            clk,
  input  logic            adv,
  input  tps_pkg::vec3_t  vert_i,
  input  tps_pkg::nrm3_t  normal_i,
  input  tps_pkg::vec3_t  origin_i,
  output tps_pkg::side_t  side_o,
  output tps_pkg::vec3_t  vert_o
);
  import tps_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  vec3_t                    vert1_r, vert2_r;
  side_t                    side_r, side_nxt;

  always_comb begin
    dx = DIFF_W'(vert_i.x) - DIFF_W'(origin_i.x);
    dy = DIFF_W'(vert_i.y) - DIFF_W'(origin_i.y);
    dz = DIFF_W'(vert_i.z) - DIFF_W'(origin_i.z);
    px_nxt = PROD_W'(normal_i.x) * PROD_W'(dx);
    py_nxt = PROD_W'(normal_i.y) * PROD_W'(dy);
    pz_nxt = PROD_W'(normal_i.z) * PROD_W'(dz);
    side_nxt = SIDE_W'(px_r) + SIDE_W'(py_r) + SIDE_W'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      vert1_r <= vert_i;
      side_r  <= side_nxt;
      vert2_r <= vert1_r;
    end
  end

  assign side_o = side_r;
  assign vert_o = vert2_r;

endmodule

// ----- hdl/tps_cross_lane.sv -----
`timescale 1ns / 1ps

// One edge crossing on one axis: l - sl*(o-l)/(so-sl), truncating.
// Split multiply, sum, then one restoring quotient bit per stage.
module tps_cross_lane (
  input  logic           clk,
  input  logic           adv,
  input  tps_pkg::coord_t lone_c_i,
  input  tps_pkg::coord_t other_c_i,
  input  tps_pkg::side_t  lone_s_i,
  input  tps_pkg::side_t  other_s_i,
  output tps_pkg::coord_t cross_o
);
  import tps_pkg::*;

  logic signed [DIFF_W-1:0] d;
  logic signed [SIDE_W:0]   den;
  logic [SIDE_W-1:0]        slm_full;
  logic [SIDE_W:0]          denm_full;

  // stage 1
  coord_t              l1_r;
  logic                neg1_r;
  logic [SLM_W-1:0]    slm1_r;
  logic [DIFF_W-1:0]   dm1_r;
  logic [DENM_W-1:0]   denm1_r;
  // stage 2
  coord_t                              l2_r;
  logic                                neg2_r;
  logic [DENM_W-1:0]                   denm2_r;
  logic [SPLIT_W+DIFF_W-1:0]           pplo_r;
  logic [SLM_W-SPLIT_W+DIFF_W-1:0]     pphi_r;
  logic [NUM_W-1:0]                    nsum;
  // divider stages
  logic [DENM_W-1:0] rem_r  [0:QUO_W];
  logic [QUO_W-1:0]  low_r  [0:QUO_W];
  logic [QUO_W-1:0]  q_r    [0:QUO_W];
  logic [DENM_W-1:0] den_r  [0:QUO_W];
  coord_t            l_r    [0:QUO_W];
  logic              neg_r  [0:QUO_W];
  logic [DENM_W-1:0] rem_nxt [0:QUO_W-1];
  logic              qb_nxt  [0:QUO_W-1];
  logic [DENM_W:0]   trial   [0:QUO_W-1];
  logic [DENM_W:0]   tsub    [0:QUO_W-1];
  coord_t            res_r;

  always_comb begin
    d         = DIFF_W'(other_c_i) - DIFF_W'(lone_c_i);
    den       = (SIDE_W+1)'(other_s_i) - (SIDE_W+1)'(lone_s_i);
    slm_full  = lone_s_i[SIDE_W-1] ? SIDE_W'(-lone_s_i) : SIDE_W'(lone_s_i);
    denm_full = den[SIDE_W] ? (SIDE_W+1)'(-den) : (SIDE_W+1)'(den);
    nsum = {pphi_r, {SPLIT_W{1'b0}}} + NUM_W'(pplo_r);
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]   = {rem_r[k], low_r[k][QUO_W-1]};
      tsub[k]    = trial[k] - {1'b0, den_r[k]};
      qb_nxt[k]  = (trial[k] >= {1'b0, den_r[k]});
      rem_nxt[k] = qb_nxt[k] ? tsub[k][DENM_W-1:0] : trial[k][DENM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r    <= lone_c_i;
      neg1_r  <= lone_s_i[SIDE_W-1] ^ d[DIFF_W-1] ^ den[SIDE_W];
      slm1_r  <= slm_full[SLM_W-1:0];
      dm1_r   <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      denm1_r <= denm_full[DENM_W-1:0];

      l2_r    <= l1_r;
      neg2_r  <= neg1_r;
      denm2_r <= denm1_r;
      pplo_r  <= slm1_r[SPLIT_W-1:0] * dm1_r;
      pphi_r  <= slm1_r[SLM_W-1:SPLIT_W] * dm1_r;

      rem_r[0] <= DENM_W'(nsum[NUM_W-1:QUO_W]);
      low_r[0] <= nsum[QUO_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= denm2_r;
      l_r[0]   <= l2_r;
      neg_r[0] <= neg2_r;
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        low_r[k+1] <= {low_r[k][QUO_W-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QUO_W-2:0], qb_nxt[k]};
        den_r[k+1] <= den_r[k];
        l_r[k+1]   <= l_r[k];
        neg_r[k+1] <= neg_r[k];
      end

      res_r <= neg_r[QUO_W] ? l_r[QUO_W] + coord_t'(q_r[QUO_W][COORD_W-1:0])
                            : l_r[QUO_W] - coord_t'(q_r[QUO_W][COORD_W-1:0]);
    end
  end

  assign cross_o = res_r;

endmodule

// ----- hdl/triangle_plane_slice_core.sv -----
`timescale 1ns / 1ps

// Triangle/plane slicer. Each in_ transaction carries one triangle; each
// out_ transaction returns whether the configured plane cuts it and, if so,
// the two crossing points (start, end) in Q16.16, zero otherwise. The block
// is fully pipelined: one triangle per clock unless the output stalls, and
// its depth is dominated by the 33 quotient stages of each crossing
// divider. Three plane-evaluation lanes form the vertex sides, a merge stage
// finds the lone vertex, then six crossing lanes (start/end times x/y/z) run
// in parallel. A backpressured output stalls the whole pipe. Registers sit on
// the cfg_ APB port (normal x/y/z at 0x00..0x08, origin x/y/z at 0x0C..0x14)
// and must only be written while the block is drained.
module triangle_plane_slice_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tps_pkg::tri_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tps_pkg::seg_out_t             out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tps_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [tps_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [tps_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import tps_pkg::*;

  // config registers
  nrm3_t normal_r;
  vec3_t origin_r;
  logic  cfg_wr;
  logic [2:0] cfg_idx;

  // pipeline control: whole pipe moves when the output slot is free or drains
  logic adv;
  logic vld_r [0:PIPE_LAT-1];
  logic cut_r [0:LANE_LAT];

  vec3_t vin [3];
  vec3_t vdel [3];
  side_t side [3];

  // merge stage
  logic [1:0] sg [3];
  logic       pos_all, neg_all, lone0, lone1, lone2, cut_nxt;
  vec3_t      lv, sv, ev;
  side_t      ls, ss, es;
  vec3_t      lv_r, sv_r, ev_r;
  side_t      ls_r, ss_r, es_r;

  coord_t st_x, st_y, st_z, en_x, en_y, en_z;

  seg_out_t out_data_r;
  logic     out_valid_r;

  localparam logic [1:0] SG_ZERO = 2'b00;
  localparam logic [1:0] SG_POS  = 2'b01;
  localparam logic [1:0] SG_NEG  = 2'b11;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[PADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r.x <= '0;
      normal_r.y <= '0;
      normal_r.z <= NORMAL_Z_RST;
      origin_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NORMAL_X: normal_r.x <= cfg_pwdata[NORM_W-1:0];
        REG_NORMAL_Y: normal_r.y <= cfg_pwdata[NORM_W-1:0];
        REG_NORMAL_Z: normal_r.z <= cfg_pwdata[NORM_W-1:0];
        REG_ORIGIN_X: origin_r.x <= cfg_pwdata;
        REG_ORIGIN_Y: origin_r.y <= cfg_pwdata;
        REG_ORIGIN_Z: origin_r.z <= cfg_pwdata;
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NORMAL_X: cfg_prdata = PDATA_W'(unsigned'(normal_r.x));
      REG_NORMAL_Y: cfg_prdata = PDATA_W'(unsigned'(normal_r.y));
      REG_NORMAL_Z: cfg_prdata = PDATA_W'(unsigned'(normal_r.z));
      REG_ORIGIN_X: cfg_prdata = origin_r.x;
      REG_ORIGIN_Y: cfg_prdata = origin_r.y;
      REG_ORIGIN_Z: cfg_prdata = origin_r.z;
      default:      cfg_prdata = '0;
    endcase
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // plane evaluation lanes, one per vertex
  assign vin[0] = '{x: in_data.vert0_x, y: in_data.vert0_y, z: in_data.vert0_z};
  assign vin[1] = '{x: in_data.vert1_x, y: in_data.vert1_y, z: in_data.vert1_z};
  assign vin[2] = '{x: in_data.vert2_x, y: in_data.vert2_y, z: in_data.vert2_z};

  for (genvar v = 0; v < 3; v++) begin : g_side
    tps_side_lane u_side (
      .clk      (clk),
      .adv      (adv),
      .vert_i   (vin[v]),
      .normal_i (normal_r),
      .origin_i (origin_r),
      .side_o   (side[v]),
      .vert_o   (vdel[v])
    );
  end

  // merge: classify signs, pick the lone vertex and its two partners
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      if (side[v][SIDE_W-1])  sg[v] = SG_NEG;
      else if (side[v] != '0) sg[v] = SG_POS;
      else                    sg[v] = SG_ZERO;
    end
    pos_all = (sg[0] != SG_NEG) && (sg[1] != SG_NEG) && (sg[2] != SG_NEG);
    neg_all = (sg[0] != SG_POS) && (sg[1] != SG_POS) && (sg[2] != SG_POS);
    lone0   = (sg[0] != sg[1]) && (sg[0] != sg[2]);
    lone1   = (sg[1] != sg[0]) && (sg[1] != sg[2]);
    lone2   = (sg[2] != sg[0]) && (sg[2] != sg[1]);
    cut_nxt = !pos_all && !neg_all && (lone0 || lone1 || lone2);
    if (lone0) begin
      lv = vdel[0]; ls = side[0];
      sv = vdel[2]; ss = side[2];
      ev = vdel[1]; es = side[1];
    end else if (lone1) begin
      lv = vdel[1]; ls = side[1];
      sv = vdel[2]; ss = side[2];
      ev = vdel[0]; es = side[0];
    end else begin
      lv = vdel[2]; ls = side[2];
      sv = vdel[0]; ss = side[0];
      ev = vdel[1]; es = side[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lv_r <= lv; sv_r <= sv; ev_r <= ev;
      ls_r <= ls; ss_r <= ss; es_r <= es;
      cut_r[0] <= cut_nxt;
      for (int k = 1; k <= LANE_LAT; k++) cut_r[k] <= cut_r[k-1];
    end
  end

  // six crossing lanes
  tps_cross_lane u_sx (.clk(clk), .adv(adv), .lone_c_i(lv_r.x), .other_c_i(sv_r.x),
                       .lone_s_i(ls_r), .other_s_i(ss_r), .cross_o(st_x));
  tps_cross_lane u_sy (.clk(clk), .adv(adv), .lone_c_i(lv_r.y), .other_c_i(sv_r.y),
                       .lone_s_i(ls_r), .other_s_i(ss_r), .cross_o(st_y));
  tps_cross_lane u_sz (.clk(clk), .adv(adv), .lone_c_i(lv_r.z), .other_c_i(sv_r.z),
                       .lone_s_i(ls_r), .other_s_i(ss_r), .cross_o(st_z));
  tps_cross_lane u_ex (.clk(clk), .adv(adv), .lone_c_i(lv_r.x), .other_c_i(ev_r.x),
                       .lone_s_i(ls_r), .other_s_i(es_r), .cross_o(en_x));
  tps_cross_lane u_ey (.clk(clk), .adv(adv), .lone_c_i(lv_r.y), .other_c_i(ev_r.y),
                       .lone_s_i(ls_r), .other_s_i(es_r), .cross_o(en_y));
  tps_cross_lane u_ez (.clk(clk), .adv(adv), .lone_c_i(lv_r.z), .other_c_i(ev_r.z),
                       .lone_s_i(ls_r), .other_s_i(es_r), .cross_o(en_z));

  // output register; uncut triangles read all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cut_r[LANE_LAT]) begin
        out_data_r <= '{cut: 1'b1, start_x: st_x, start_y: st_y, start_z: st_z,
                        end_x: en_x, end_y: en_y, end_z: en_z};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/tps_checker.sv -----
`timescale 1ns / 1ps

module tps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tps_pkg::seg_out_t out_data
);
  import tps_pkg::*;

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_nocut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cut |-> out_data == '0)
    else $error("uncut result not zero");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind triangle_plane_slice_core tps_checker u_tps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  seg_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  always #2 clk = ~clk;

  triangle_plane_slice_core i_dut (.*);

  // Predictor copy of the plane registers.
  logic signed [NORM_W-1:0]  plane_nrm [3];
  logic signed [COORD_W-1:0] plane_org [3];

  seg_out_t seg_expected_q [$];
  int   fail_cnt = 0;
  int   idle_cycles = 0;
  logic run_done = 1'b0;

  // Crossing l - sl*(o-l)/(so-sl), truncated toward zero, exact in 128 bits.
  function automatic coord_t edge_cross(longint l, longint o, longint sl, longint so);
    logic signed [127:0] num;
    logic signed [127:0] quo;
    longint d;
    longint den;
    d   = o - l;
    den = so - sl;
    if (den == 0 || sl == 0 || d == 0) return coord_t'(l);
    num = 128'(sl) * 128'(d);
    quo = num / 128'(den);   // SV signed division truncates toward zero
    return coord_t'(l - longint'(quo));
  endfunction

  function automatic int sign_of(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic seg_out_t slice_triangle(tri_in_t t);
    seg_out_t r;
    longint vtx [3][3];
    longint side [3];
    int lone, to_s, to_e;
    vtx[0][0] = t.vert0_x; vtx[0][1] = t.vert0_y; vtx[0][2] = t.vert0_z;
    vtx[1][0] = t.vert1_x; vtx[1][1] = t.vert1_y; vtx[1][2] = t.vert1_z;
    vtx[2][0] = t.vert2_x; vtx[2][1] = t.vert2_y; vtx[2][2] = t.vert2_z;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      side[k] = 0;
      for (int a = 0; a < 3; a++)
        side[k] += longint'(plane_nrm[a]) * (vtx[k][a] - longint'(plane_org[a]));
    end
    if (side[0] >= 0 && side[1] >= 0 && side[2] >= 0) return r;
    if (side[0] <= 0 && side[1] <= 0 && side[2] <= 0) return r;
    lone = -1; to_s = 0; to_e = 0;
    if (sign_of(side[0]) != sign_of(side[1]) && sign_of(side[0]) != sign_of(side[2])) begin
      lone = 0; to_s = 2; to_e = 1;
    end else if (sign_of(side[1]) != sign_of(side[0]) &&
                 sign_of(side[1]) != sign_of(side[2])) begin
      lone = 1; to_s = 2; to_e = 0;
    end else if (sign_of(side[2]) != sign_of(side[0]) &&
                 sign_of(side[2]) != sign_of(side[1])) begin
      lone = 2; to_s = 0; to_e = 1;
    end
    if (lone < 0) return r;
    r.cut     = 1'b1;
    r.start_x = edge_cross(vtx[lone][0], vtx[to_s][0], side[lone], side[to_s]);
    r.start_y = edge_cross(vtx[lone][1], vtx[to_s][1], side[lone], side[to_s]);
    r.start_z = edge_cross(vtx[lone][2], vtx[to_s][2], side[lone], side[to_s]);
    r.end_x   = edge_cross(vtx[lone][0], vtx[to_e][0], side[lone], side[to_e]);
    r.end_y   = edge_cross(vtx[lone][1], vtx[to_e][1], side[lone], side[to_e]);
    r.end_z   = edge_cross(vtx[lone][2], vtx[to_e][2], side[lone], side[to_e]);
    return r;
  endfunction

  // Receiver stall pattern: alternates free-running stretches with random stalls.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom & 3) != 0;
      default: out_ready <= ($urandom & 3) == 0;
    endcase
  end

  // Result checker.
  always @(posedge clk) begin
    seg_out_t exp_seg;
    if (rst_n && out_valid && out_ready) begin
      if (seg_expected_q.size() == 0) begin
        $error("result with no expected segment pending");
        fail_cnt++;
      end else begin
        exp_seg = seg_expected_q.pop_front();
        if (out_data.cut !== exp_seg.cut) begin
          $error("cut exp %0d act %0d", exp_seg.cut, out_data.cut); fail_cnt++;
        end
        if (out_data.start_x !== exp_seg.start_x) begin
          $error("start_x exp %0d act %0d", exp_seg.start_x, out_data.start_x); fail_cnt++;
        end
        if (out_data.start_y !== exp_seg.start_y) begin
          $error("start_y exp %0d act %0d", exp_seg.start_y, out_data.start_y); fail_cnt++;
        end
        if (out_data.start_z !== exp_seg.start_z) begin
          $error("start_z exp %0d act %0d", exp_seg.start_z, out_data.start_z); fail_cnt++;
        end
        if (out_data.end_x !== exp_seg.end_x) begin
          $error("end_x exp %0d act %0d", exp_seg.end_x, out_data.end_x); fail_cnt++;
        end
        if (out_data.end_y !== exp_seg.end_y) begin
          $error("end_y exp %0d act %0d", exp_seg.end_y, out_data.end_y); fail_cnt++;
        end
        if (out_data.end_z !== exp_seg.end_z) begin
          $error("end_z exp %0d act %0d", exp_seg.end_z, out_data.end_z); fail_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || run_done ||
        seg_expected_q.size() == 0 && !in_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender burst/gap state.
  int burst_left = 0;

  // Valid stays high across a burst; it drops only for a gap or a drain.
  task automatic send_triangle(tri_in_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom & 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    seg_expected_q.push_back(slice_triangle(t));
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (seg_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // APB write: setup then access phase, then the bus returns to idle.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= PADDR_W'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx < 3) plane_nrm[idx] = val[NORM_W-1:0];
    else plane_org[idx-3] = val;
    @(posedge clk);
  endtask

  task automatic set_plane(logic [NORM_W-1:0] nx, logic [NORM_W-1:0] ny,
                           logic [NORM_W-1:0] nz, coord_t ox, coord_t oy, coord_t oz);
    drain_pipe();
    reg_write(REG_NORMAL_X, 32'(nx));
    reg_write(REG_NORMAL_Y, 32'(ny));
    reg_write(REG_NORMAL_Z, 32'(nz));
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
  endtask

  function automatic tri_in_t make_tri(coord_t ax, coord_t ay, coord_t az,
                                       coord_t bx, coord_t by, coord_t bz,
                                       coord_t cx, coord_t cy, coord_t cz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  // Coordinate: mostly modest, sometimes full range or extremes.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return ($urandom & 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return coord_t'($urandom_range(0, 255)) - 128;
      default: return coord_t'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] rand_norm();
    case ($urandom_range(0, 4))
      0: return ($urandom & 1) ? 18'h1ffff : 18'h20000;
      1: return 18'($urandom_range(0, 4)) - 18'd2;
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic test_reset_plane();
    // Reset plane z = 0: straddling, on-plane, and all-one-side triangles.
    plane_nrm[0] = '0; plane_nrm[1] = '0; plane_nrm[2] = NORMAL_Z_RST;
    plane_org[0] = '0; plane_org[1] = '0; plane_org[2] = '0;
    send_triangle(make_tri(0, 0, 32'sh10000, 32'sh10000, 0, -32'sh10000, 0, 32'sh10000, 32'sh20000));
    send_triangle(make_tri(0, 0, -5, 7, 3, 9, -4, 11, 13));
    send_triangle(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 9));
    send_triangle(make_tri(1, 2, -3, 4, 5, -6, 7, 8, -9));
    send_triangle(make_tri(1, 2, 0, 4, 5, 0, 7, 8, 0));
    // one vertex on the plane, the others on opposite sides
    send_triangle(make_tri(5, 5, 0, 10, 3, 100, -7, 2, -100));
    send_triangle(make_tri(10, 3, 100, 5, 5, 0, -7, 2, -100));
    send_triangle(make_tri(10, 3, 100, -7, 2, -100, 5, 5, 0));
    // lone vertex 1 and 2
    send_triangle(make_tri(3, 4, 10, -9, 8, -20, 6, 1, 30));
    send_triangle(make_tri(3, 4, 10, -9, 8, 20, 6, 1, -30));
    // extremes of the coordinate range
    send_triangle(make_tri(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send_triangle(make_tri(-1, -1, -1, 0, 0, 1, 32'sh7fffffff, -1, 32'sh7fffffff));
  endtask

  task automatic test_extreme_planes();
    set_plane(18'h1ffff, 18'h20000, 18'h1ffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    repeat (6) send_triangle(make_tri(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord()));
    set_plane(18'h20000, 18'h20000, 18'h20000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    repeat (6) send_triangle(make_tri(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic test_random_slices();
    tri_in_t t;
    for (int phase = 0; phase < 8; phase++) begin
      set_plane(rand_norm(), rand_norm(), rand_norm(), rand_coord(), rand_coord(), rand_coord());
      for (int n = 0; n < 210; n++) begin
        t = make_tri(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
        // Sometimes place a vertex exactly at the plane origin.
        if (($urandom & 15) == 0) begin
          t.vert1_x = plane_org[0]; t.vert1_y = plane_org[1]; t.vert1_z = plane_org[2];
        end
        send_triangle(t);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_plane();
    test_extreme_planes();
    test_random_slices();
    drain_pipe();
    run_done = 1'b1;
    if (fail_cnt == 0 && seg_expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tps_pkg.sv
hdl/tps_side_lane.sv
hdl/tps_cross_lane.sv
hdl/triangle_plane_slice_core.sv
hdl/tps_checker.sv
bench/tb.sv
